/* src/cfae_pkg.sv */
`default_nettype none

package cfae_pkg;

  localparam int unsigned LineLen = 31;
  localparam int unsigned MaxBytes = 8;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharData  = 8'h74;
  localparam logic [7:0] CharRemote = 8'h72;
  localparam logic [7:0] CaseShift = 8'h20;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [7:0]  chr;
  } cell_t;

  typedef struct packed {
    logic        remote_request;
    logic        extended_id;
    logic [28:0] identifier;
    logic [3:0]  data_length;
    logic [63:0] payload;
    logic [15:0] timestamp;
  } frame_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CharZero + {4'b0, nib};
    end else begin
      c = CharLowA + {4'b0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/cfae_format.sv */
`default_nettype none

module cfae_format (
  input  var cfae_pkg::frame_t frame_i,
  input  wire logic            ts_mode_i,
  output var cfae_pkg::cell_t  line_o [cfae_pkg::LineLen]
);

  logic [3:0]  len_sat;
  logic [3:0]  hd;
  logic [4:0]  ds;
  logic [4:0]  de;
  logic [4:0]  te;
  logic [31:0] id32;
  logic [7:0]  lead;

  always_comb begin
    len_sat = (frame_i.data_length > 4'(cfae_pkg::MaxBytes)) ?
              4'(cfae_pkg::MaxBytes) : frame_i.data_length;
    hd      = frame_i.extended_id ? 4'd9 : 4'd4;
    ds      = {1'b0, hd} + 5'd1;
    de      = ds + {len_sat, 1'b0};
    te      = de + (ts_mode_i ? 5'd4 : 5'd0);
    id32    = frame_i.extended_id ? {3'b0, frame_i.identifier}
                                  : {21'b0, frame_i.identifier[10:0]};
    lead    = frame_i.remote_request ? cfae_pkg::CharRemote : cfae_pkg::CharData;
    if (frame_i.extended_id) begin
      lead = lead - cfae_pkg::CaseShift;
    end
  end

  always_comb begin
    logic [4:0] pos;
    logic [4:0] dif;
    logic [2:0] nib;
    logic [3:0] idx;
    logic [1:0] r;
    for (int p = 0; p < cfae_pkg::LineLen; p++) begin
      pos = 5'(p);
      dif = '0;
      nib = '0;
      idx = '0;
      r   = '0;
      line_o[p].valid = 1'b1;
      line_o[p].last  = 1'b0;
      line_o[p].chr   = '0;
      priority if (pos == 5'd0) begin
        line_o[p].chr = lead;
      end else if (pos < {1'b0, hd}) begin
        dif = {1'b0, hd} - pos - 5'd1;
        nib = dif[2:0];
        line_o[p].chr = cfae_pkg::hex_char(id32[{nib, 2'b00} +: 4]);
      end else if (pos == {1'b0, hd}) begin
        line_o[p].chr = cfae_pkg::CharZero + {4'b0, len_sat};
      end else if (pos < de) begin
        dif = pos - ds;
        idx = {dif[3:1], ~dif[0]};
        line_o[p].chr = cfae_pkg::hex_char(frame_i.payload[{idx, 2'b00} +: 4]);
      end else if (pos < te) begin
        dif = pos - de;
        r   = ~dif[1:0];
        line_o[p].chr = cfae_pkg::hex_char(frame_i.timestamp[{r, 2'b00} +: 4]);
      end else if (pos == te) begin
        line_o[p].chr  = cfae_pkg::CharCr;
        line_o[p].last = 1'b1;
      end else begin
        line_o[p].valid = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/cfae_cell.sv */
`default_nettype none

module cfae_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire logic            shift_i,
  input  var cfae_pkg::cell_t  load_data_i,
  input  var cfae_pkg::cell_t  next_i,
  output var cfae_pkg::cell_t  cell_o
);

  logic       valid_q, valid_d;
  logic       last_q, last_d;
  logic [7:0] chr_q, chr_d;

  always_comb begin
    valid_d = valid_q;
    last_d  = last_q;
    chr_d   = chr_q;
    priority if (load_i) begin
      valid_d = load_data_i.valid;
      last_d  = load_data_i.last;
      chr_d   = load_data_i.chr;
    end else if (shift_i) begin
      valid_d = next_i.valid;
      last_d  = next_i.last;
      chr_d   = next_i.chr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    chr_q  <= chr_d;
  end

  assign cell_o = '{valid: valid_q, last: last_q, chr: chr_q};

endmodule

`default_nettype wire

/* src/can_frame_ascii_encoder.sv */
// The accepted frame word is registered in the input register, then loaded into the chain.
// Throughput: one character per cycle while out_ready_i is high; a line of 6 to 31
// characters drains through the 31-cell character shift chain, one cell per cycle unless stalled.
// The next frame waits in a one-word input register and enters the chain back to back.
// Reset clears all valid bits and the timestamp mode bit; no clearing pass.
`default_nettype none

module can_frame_ascii_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output wire logic        in_ready_o,
  input  wire logic        remote_request_i,
  input  wire logic        extended_id_i,
  input  wire logic [28:0] identifier_i,
  input  wire logic [3:0]  data_length_i,
  input  wire logic [63:0] payload_i,
  input  wire logic [15:0] timestamp_i,
  output wire logic        out_valid_o,
  input  wire logic        out_ready_i,
  output wire logic [7:0]  character_o,
  output wire logic        last_o
);

  localparam int unsigned N = cfae_pkg::LineLen;

  logic             ts_mode_q;
  logic             frm_valid_q, frm_valid_d;
  cfae_pkg::frame_t frm_q;
  cfae_pkg::cell_t  line   [N];
  cfae_pkg::cell_t  cells  [N];
  cfae_pkg::cell_t  nexts  [N];
  logic             shift;
  logic             load;
  logic             in_take;

  assign shift   = !cells[0].valid || out_ready_i;
  assign load    = frm_valid_q && !cells[1].valid && shift;
  assign in_ready_o = !frm_valid_q || load;
  assign in_take = in_valid_i && in_ready_o;

  always_comb begin
    frm_valid_d = frm_valid_q;
    priority if (in_take) begin
      frm_valid_d = 1'b1;
    end else if (load) begin
      frm_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_mode_q   <= 1'b0;
      frm_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ts_mode_q <= cfg_wdata_i;
      end
      frm_valid_q <= frm_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      frm_q <= '{remote_request: remote_request_i, extended_id: extended_id_i,
                 identifier: identifier_i, data_length: data_length_i,
                 payload: payload_i, timestamp: timestamp_i};
    end
  end

  cfae_format u_format (
    .frame_i   (frm_q),
    .ts_mode_i (ts_mode_q),
    .line_o    (line)
  );

  for (genvar k = 0; k < N; k++) begin : g_cell
    if (k == N - 1) begin : g_tail
      assign nexts[k] = '0;
    end else begin : g_mid
      assign nexts[k] = cells[k+1];
    end
    cfae_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .shift_i     (shift),
      .load_data_i (line[k]),
      .next_i      (nexts[k]),
      .cell_o      (cells[k])
    );
  end

  assign out_valid_o = cells[0].valid;
  assign character_o = cells[0].chr;
  assign last_o      = cells[0].last;

  a_load_shows_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o && (character_o == cfae_pkg::CharData ||
             character_o == cfae_pkg::CharRemote ||
             character_o == cfae_pkg::CharData - cfae_pkg::CaseShift ||
             character_o == cfae_pkg::CharRemote - cfae_pkg::CaseShift))
    else $error("line does not start with a frame type letter");

  a_last_is_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !cells[1].valid)
    else $error("characters queued behind the end of a line");

  a_line_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> cells[1].valid)
    else $error("gap inside a line");

  a_frame_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_valid_q && !load |=> frm_valid_q)
    else $error("pending frame word dropped");

  a_last_is_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> character_o == cfae_pkg::CharCr)
    else $error("line end without carriage return");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 8;
  localparam string HexDigits = "0123456789abcdef";

  typedef struct {
    logic [7:0] chr;
    logic       last;
  } line_char_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   cfg_we = 1'b0;
  logic   cfg_wdata = 1'b0;
  logic   in_valid = 1'b0;
  cfae_pkg::frame_t in_frame = '0;
  logic   out_ready = 1'b0;

  wire logic       in_ready;
  wire logic       out_valid;
  wire logic [7:0] out_char;
  wire logic       out_last;

  line_char_t  pending_chars[$];
  bit          ts_mode = 1'b0;
  bit          allow_gaps = 1'b1;
  int unsigned mismatches = 0;
  int unsigned stall_left = 0;

  can_frame_ascii_encoder i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .remote_request_i (in_frame.remote_request),
    .extended_id_i    (in_frame.extended_id),
    .identifier_i     (in_frame.identifier),
    .data_length_i    (in_frame.data_length),
    .payload_i        (in_frame.payload),
    .timestamp_i      (in_frame.timestamp),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .character_o      (out_char),
    .last_o           (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    return HexDigits[nib];
  endfunction

  function automatic void push_char(input logic [7:0] chr, input logic last);
    line_char_t c;
    c.chr = chr;
    c.last = last;
    pending_chars.push_back(c);
  endfunction

  function automatic void encode_frame_text(input cfae_pkg::frame_t f);
    logic [7:0]  lead;
    logic [31:0] ext_id;
    logic [11:0] std_id;
    logic [7:0]  data_byte;
    int unsigned nbytes;
    lead = f.remote_request ? cfae_pkg::CharRemote : cfae_pkg::CharData;
    ext_id = {3'b000, f.identifier};
    std_id = {1'b0, f.identifier[10:0]};
    nbytes = (f.data_length > cfae_pkg::MaxBytes) ? cfae_pkg::MaxBytes : f.data_length;
    if (f.extended_id) begin
      push_char(lead - cfae_pkg::CaseShift, 1'b0);
      for (int k = 7; k >= 0; k--) push_char(nibble_char(ext_id[4*k +: 4]), 1'b0);
    end else begin
      push_char(lead, 1'b0);
      for (int k = 2; k >= 0; k--) push_char(nibble_char(std_id[4*k +: 4]), 1'b0);
    end
    push_char(cfae_pkg::CharZero + 8'(nbytes), 1'b0);
    for (int j = 0; j < nbytes; j++) begin
      data_byte = f.payload[8*j +: 8];
      push_char(nibble_char(data_byte[7:4]), 1'b0);
      push_char(nibble_char(data_byte[3:0]), 1'b0);
    end
    if (ts_mode) begin
      for (int k = 3; k >= 0; k--) push_char(nibble_char(f.timestamp[4*k +: 4]), 1'b0);
    end
    push_char(cfae_pkg::CharCr, 1'b1);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_frame(input logic rtr, input logic ext, input logic [28:0] id,
                            input logic [3:0] len, input logic [63:0] data,
                            input logic [15:0] stamp);
    cfae_pkg::frame_t f;
    f.remote_request = rtr;
    f.extended_id = ext;
    f.identifier = id;
    f.data_length = len;
    f.payload = data;
    f.timestamp = stamp;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame <= f;
    do @(posedge clk); while (!in_ready);
    encode_frame_text(f);
  endtask

  task automatic drain_lines();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic set_timestamp_mode(input bit mode);
    drain_lines();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    ts_mode = mode;
  endtask

  task automatic test_standard_frames();
    send_frame(1'b0, 1'b0, 29'h0, 4'd0, 64'h0, 16'h0);
    send_frame(1'b0, 1'b0, 29'h1FFFFFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_frame(1'b1, 1'b0, 29'h7FF, 4'd3, 64'h0123_4567_89AB_CDEF, 16'h0);
    send_frame(1'b0, 1'b0, 29'h1555_5A5, 4'd5, 64'h0, 16'h1234);
  endtask

  task automatic test_extended_frames();
    send_frame(1'b0, 1'b1, 29'h0, 4'd0, 64'h0, 16'h0);
    send_frame(1'b0, 1'b1, 29'h1FFFFFFF, 4'd8, 64'hFEDC_BA98_7654_3210, 16'h0);
    send_frame(1'b1, 1'b1, 29'h1234_5678, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
    send_frame(1'b1, 1'b1, 29'h0ABC_DEF0, 4'd0, 64'h0, 16'h0);
  endtask

  task automatic test_length_saturation();
    send_frame(1'b0, 1'b0, 29'h123, 4'd9, 64'h1122_3344_5566_7788, 16'h0);
    send_frame(1'b1, 1'b1, 29'h1000_0000, 4'd12, 64'hA5A5_5A5A_0F0F_F0F0, 16'h0);
    send_frame(1'b0, 1'b1, 29'h0000_0001, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
  endtask

  task automatic test_timestamp_digits();
    set_timestamp_mode(1'b1);
    send_frame(1'b0, 1'b0, 29'h321, 4'd1, 64'hAB, 16'd0);
    send_frame(1'b0, 1'b1, 29'h1FFFFFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 16'd59999);
    send_frame(1'b1, 1'b0, 29'h0, 4'd0, 64'h0, 16'hFFFF);
    send_frame(1'b0, 1'b0, 29'h7FF, 4'd15, 64'h0, 16'hBEEF);
  endtask

  task automatic test_random_traffic(input int unsigned count, input bit mode, input bit gaps);
    logic [28:0] id;
    logic [3:0]  len;
    logic [15:0] stamp;
    set_timestamp_mode(mode);
    allow_gaps = gaps;
    repeat (count) begin
      id = 29'($urandom());
      len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                          4'($urandom_range(0, 8));
      stamp = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 59999));
      send_frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), id, len,
                 {$urandom(), $urandom()}, stamp);
    end
  endtask

  always @(posedge clk) begin : char_sink
    line_char_t want;
    logic       ready_next;
    if (out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected character", out_char, 8'h00);
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.chr) report_mismatch("character", out_char, want.chr);
        if (out_last !== want.last) report_mismatch("last", {7'b0, out_last}, {7'b0, want.last});
      end
    end
    if (!allow_gaps) begin
      stall_left = 0;
      ready_next = 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    out_ready <= ready_next;
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_standard_frames();
    test_extended_frames();
    test_length_saturation();
    test_timestamp_digits();
    test_random_traffic(32, 1'b0, 1'b1);
    test_random_traffic(32, 1'b1, 1'b1);
    test_random_traffic(32, 1'b0, 1'b1);
    test_random_traffic(32, 1'b1, 1'b1);
    test_random_traffic(20, 1'b1, 1'b0);
    drain_lines();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
